FILE: rtl/csvcie_pkg.sv
// ----------------------------------------------------------------------------
// csvcie_pkg
// Shared widths, character codes, register indexes, request types and helper
// functions for the CSV column integer extractor.
// ----------------------------------------------------------------------------
package csvcie_pkg;

    localparam int MAX_COLUMNS = 64;
    localparam int MASK_W      = 64;
    localparam int COL_W       = 6;
    localparam int CC_W        = COL_W + 1;
    localparam int ROW_W       = 32;
    localparam int VAL_W       = 64;
    localparam int BYTE_W      = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    localparam logic [BYTE_W-1:0] FIELD_SEP_RST = 8'd44;
    localparam logic [BYTE_W-1:0] GROUP_SEP_RST = 8'd44;
    localparam logic [ROW_W-1:0]  ROW_MAX       = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIELD_SEP = 3'd0,
        CFG_GROUP_SEP = 3'd1,
        CFG_COL_MASK  = 3'd2,
        CFG_ROWS_SKIP = 3'd3,
        CFG_ROW_LIMIT = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_VALUE = 2'd0,
        ST_SHORT = 2'd1,
        ST_LIMIT = 2'd2
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] field_sep;
        logic [BYTE_W-1:0] group_sep;
        logic [MASK_W-1:0] col_mask;
        logic [ROW_W-1:0]  rows_to_skip;
        logic [ROW_W-1:0]  row_limit;
    } t_cfg;

    // one result to build: for a short row col is the column searched above
    typedef struct packed {
        t_status         kind;
        logic [CC_W-1:0] col;
        logic            last;
    } t_res_req;

    // all results caused by one byte; the second one never carries a value
    typedef struct packed {
        t_res_req         req_a;
        t_res_req         req_b;
        logic             has_b;
        logic [VAL_W-1:0] acc;
        logic             neg;
        logic [ROW_W-1:0] row;
    } t_q_entry;

    function automatic logic [MASK_W-1:0] sel_cols(input logic [MASK_W-1:0] mask);
        logic [MASK_W-1:0] s;
        for (int i = 0; i < MASK_W; i++) begin
            s[i] = mask[i] && (i < MAX_COLUMNS);
        end
        return s;
    endfunction

    // bit i set where column i lies beyond column cc
    function automatic logic [MASK_W-1:0] above_cc(input logic [CC_W-1:0] cc);
        logic [MASK_W-1:0] m;
        for (int i = 0; i < MASK_W; i++) begin
            m[i] = (CC_W'(i) > cc);
        end
        return m;
    endfunction

endpackage

FILE: rtl/csvcie_in_if.sv
// ----------------------------------------------------------------------------
// csvcie_in_if
// Byte request channel: valid/ready handshake with text byte and end mark.
// ----------------------------------------------------------------------------
interface csvcie_in_if;
    logic                             valid;
    logic                             ready;
    logic [csvcie_pkg::BYTE_W-1:0]    data_byte;
    logic                             end_of_file;

    modport source (output valid, output data_byte, output end_of_file, input ready);
    modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

FILE: rtl/csvcie_out_if.sv
// ----------------------------------------------------------------------------
// csvcie_out_if
// Result request channel: valid/ready handshake with value, column, row,
// status and line end mark.
// ----------------------------------------------------------------------------
interface csvcie_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [csvcie_pkg::VAL_W-1:0]  value;
    logic [csvcie_pkg::COL_W-1:0]         column;
    logic [csvcie_pkg::ROW_W-1:0]         row;
    logic [1:0]                           status;
    logic                                 last_in_row;

    modport source (output valid, output value, output column, output row, output status,
                    output last_in_row, input ready);
    modport sink   (input valid, input value, input column, input row, input status,
                    input last_in_row, output ready);
endinterface

FILE: rtl/csvcie_front.sv
// ----------------------------------------------------------------------------
// csvcie_front
// Byte parser: line and field tracking, number accumulation, row counting,
// and the result requests each byte causes.
// ----------------------------------------------------------------------------
module csvcie_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    csvcie_in_if.sink             i_in,
    input  csvcie_pkg::t_cfg      i_cfg,
    input  logic                  i_q_not_full,
    output logic                  o_push,
    output csvcie_pkg::t_q_entry  o_entry
);
    import csvcie_pkg::*;

    logic [CC_W-1:0]  r_cc, n_cc;
    logic [VAL_W-1:0] r_acc, n_acc;
    logic             r_neg, n_neg;
    logic             r_at_start, n_at_start;
    logic             r_ne, n_ne;
    logic             r_lhb, n_lhb;
    logic [ROW_W-1:0] r_ln, n_ln;
    logic             r_stopped, n_stopped;
    logic             r_cr, n_cr;

    logic              v_accept;
    logic [BYTE_W-1:0] v_b;
    logic [BYTE_W-1:0] v_digit;
    logic [MASK_W-1:0] v_sel;
    logic              v_fbyte;
    logic              v_sep;
    logic              v_go;
    logic              v_close;
    logic [1:0]        v_n;
    t_q_entry          v_ent;
    t_res_req          v_req;

    assign i_in.ready = i_q_not_full;
    assign v_accept   = i_in.valid && i_q_not_full;
    assign v_b        = i_in.data_byte;
    assign v_digit    = i_in.data_byte - CH_ZERO;
    assign v_sel      = sel_cols(i_cfg.col_mask);

    always_comb begin
        n_cc       = r_cc;
        n_acc      = r_acc;
        n_neg      = r_neg;
        n_at_start = r_at_start;
        n_ne       = r_ne;
        n_lhb      = r_lhb;
        n_ln       = r_ln;
        n_stopped  = r_stopped;
        n_cr       = r_cr;
        v_fbyte    = 1'b0;
        v_sep      = 1'b0;
        v_go       = 1'b0;
        v_close    = 1'b0;
        v_n        = 2'd0;
        v_ent      = '0;
        v_req      = '0;

        if (v_accept) begin
            if (!r_stopped) begin
                if (v_b == CH_LF) begin
                    v_close = n_lhb;
                    if (!n_lhb) begin
                        // empty line, not counted
                        n_acc = '0; n_neg = 1'b0; n_at_start = 1'b1; n_ne = 1'b0;
                        n_cc  = '0; n_cr  = 1'b0;
                    end
                end else if (v_b == CH_CR && !n_lhb && !n_cr) begin
                    // first carriage return of a line is held back
                    n_cr    = 1'b1;
                    v_fbyte = 1'b1;
                end else begin
                    v_go = 1'b1;
                    if (!n_lhb) begin
                        n_lhb = 1'b1;
                        n_cr  = 1'b0;
                        if (n_ln != ROW_MAX) n_ln = n_ln + ROW_W'(1);
                        if (i_cfg.row_limit != '0 && n_ln > i_cfg.row_limit) begin
                            v_req.kind  = ST_LIMIT;
                            v_req.col   = '0;
                            v_req.last  = 1'b0;
                            v_ent.req_a = v_req;
                            v_ent.row   = n_ln;
                            v_n         = 2'd1;
                            n_stopped   = 1'b1;
                            v_go        = 1'b0;
                        end
                    end
                    if (v_go) begin
                        if (v_b != CH_CR && v_b == i_cfg.field_sep) v_sep = 1'b1;
                        else v_fbyte = 1'b1;
                    end
                end

                // number parsing within a field
                if (v_fbyte && !n_ne) begin
                    if (n_at_start && v_b == CH_MINUS) begin
                        n_neg      = 1'b1;
                        n_at_start = 1'b0;
                    end else begin
                        n_at_start = 1'b0;
                        if (!(v_b != CH_CR && v_b == i_cfg.group_sep)) begin
                            if (v_b >= CH_ZERO && v_b <= CH_NINE) begin
                                n_acc = (n_acc << 3) + (n_acc << 1)
                                      + {{(VAL_W-BYTE_W){1'b0}}, v_digit};
                            end else begin
                                n_ne = 1'b1;
                            end
                        end
                    end
                end

                // field end at a separator
                if (v_sep) begin
                    if (n_cc < CC_W'(MAX_COLUMNS) && v_sel[n_cc[COL_W-1:0]]
                            && n_ln > i_cfg.rows_to_skip) begin
                        v_req.kind  = ST_VALUE;
                        v_req.col   = n_cc;
                        v_req.last  = 1'b0;
                        v_ent.req_a = v_req;
                        v_ent.acc   = n_acc;
                        v_ent.neg   = n_neg;
                        v_ent.row   = n_ln;
                        v_n         = 2'd1;
                    end
                    if (n_cc < CC_W'(MAX_COLUMNS)) n_cc = n_cc + CC_W'(1);
                    n_acc = '0; n_neg = 1'b0; n_at_start = 1'b1; n_ne = 1'b0;
                end

                if (!v_close) v_close = i_in.end_of_file && !n_stopped && n_lhb;

                // line end
                if (v_close) begin
                    if (n_ln > i_cfg.rows_to_skip) begin
                        v_go = 1'b0;
                        if ((v_sel & above_cc(n_cc)) != '0) begin
                            v_req.kind = ST_SHORT;
                            v_go       = 1'b1;
                        end else if (n_cc < CC_W'(MAX_COLUMNS) && v_sel[n_cc[COL_W-1:0]]) begin
                            v_req.kind = ST_VALUE;
                            v_go       = 1'b1;
                        end
                        v_req.col  = n_cc;
                        v_req.last = 1'b1;
                        if (v_go) begin
                            v_ent.row = n_ln;
                            if (v_n == 2'd0) begin
                                v_ent.req_a = v_req;
                                v_ent.acc   = n_acc;
                                v_ent.neg   = n_neg;
                                v_n         = 2'd1;
                            end else begin
                                v_ent.req_b = v_req;
                                v_ent.has_b = 1'b1;
                                v_n         = 2'd2;
                            end
                        end
                    end
                    n_acc = '0; n_neg = 1'b0; n_at_start = 1'b1; n_ne = 1'b0;
                    n_cc  = '0; n_lhb = 1'b0; n_cr = 1'b0;
                end
            end

            if (i_in.end_of_file) begin
                n_acc = '0; n_neg = 1'b0; n_at_start = 1'b1; n_ne = 1'b0;
                n_cc  = '0; n_lhb = 1'b0; n_cr = 1'b0;
                n_ln  = '0; n_stopped = 1'b0;
            end
        end
    end

    assign o_push  = v_accept && (v_n != 2'd0);
    assign o_entry = v_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc       <= '0;
            r_acc      <= '0;
            r_neg      <= 1'b0;
            r_at_start <= 1'b1;
            r_ne       <= 1'b0;
            r_lhb      <= 1'b0;
            r_ln       <= '0;
            r_stopped  <= 1'b0;
            r_cr       <= 1'b0;
        end else begin
            r_cc       <= n_cc;
            r_acc      <= n_acc;
            r_neg      <= n_neg;
            r_at_start <= n_at_start;
            r_ne       <= n_ne;
            r_lhb      <= n_lhb;
            r_ln       <= n_ln;
            r_stopped  <= n_stopped;
            r_cr       <= n_cr;
        end
    end

    a_stopped_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (v_accept && r_stopped) |-> !o_push)
        else $error("request pushed after row limit");

    a_limit_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_entry.req_a.kind == ST_LIMIT) |-> !o_entry.has_b)
        else $error("row limit request paired with another");

endmodule

FILE: rtl/csvcie_queue.sv
// ----------------------------------------------------------------------------
// csvcie_queue
// Short first-in first-out queue of request entries between parser and
// result builder.
// ----------------------------------------------------------------------------
module csvcie_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  csvcie_pkg::t_q_entry  i_entry,
    output logic                  o_not_full,
    input  logic                  i_pop,
    output csvcie_pkg::t_q_entry  o_entry,
    output logic                  o_not_empty
);
    import csvcie_pkg::*;

    t_q_entry           r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_head, n_head;
    logic [Q_PTR_W-1:0] r_tail, n_tail;
    logic [Q_CNT_W-1:0] r_count, n_count;

    assign o_not_full  = (r_count != Q_CNT_W'(Q_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_entry     = r_mem[r_head];

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_push) begin
            n_tail = (r_tail == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_tail + Q_PTR_W'(1);
        end
        if (i_pop) begin
            n_head = (r_head == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_head + Q_PTR_W'(1);
        end
        if (i_push && !i_pop) n_count = r_count + Q_CNT_W'(1);
        else if (!i_push && i_pop) n_count = r_count - Q_CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_tail] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != Q_CNT_W'(Q_DEPTH) || i_pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from empty queue");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + Q_CNT_W'(1)))
        else $error("queue count lost a push");

endmodule

FILE: rtl/csvcie_back.sv
// ----------------------------------------------------------------------------
// csvcie_back
// Result builder: takes queued entries, applies sign, finds the first
// missing column of a short row, and drives the registered result channel.
// ----------------------------------------------------------------------------
module csvcie_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [csvcie_pkg::MASK_W-1:0]     i_col_mask,
    input  csvcie_pkg::t_q_entry              i_entry,
    input  logic                              i_entry_valid,
    output logic                              o_pop,
    csvcie_out_if.source                      o_out
);
    import csvcie_pkg::*;

    t_q_entry r_ent;
    logic     r_ent_v;
    logic     r_sub;

    logic                    r_out_v;
    logic signed [VAL_W-1:0] r_out_value;
    logic [COL_W-1:0]        r_out_column;
    logic [ROW_W-1:0]        r_out_row;
    t_status                 r_out_status;
    logic                    r_out_last;

    t_res_req          v_req;
    logic              v_out_free;
    logic              v_load;
    logic              v_done;
    logic [MASK_W-1:0] v_rest;
    logic [COL_W-1:0]  v_first;
    logic [VAL_W-1:0]  v_value;
    logic [COL_W-1:0]  v_column;

    assign v_req      = r_sub ? r_ent.req_b : r_ent.req_a;
    assign v_out_free = !r_out_v || o_out.ready;
    assign v_load     = v_out_free && r_ent_v;
    assign v_done     = v_load && (r_sub || !r_ent.has_b);
    assign o_pop      = i_entry_valid && (!r_ent_v || v_done);

    // first selected column beyond the last one seen
    always_comb begin
        v_rest  = sel_cols(i_col_mask) & above_cc(v_req.col);
        v_first = '0;
        for (int i = MASK_W - 1; i >= 0; i--) begin
            if (v_rest[i]) v_first = COL_W'(i);
        end
    end

    always_comb begin
        v_value  = '0;
        v_column = '0;
        case (v_req.kind)
            ST_VALUE: begin
                v_column = v_req.col[COL_W-1:0];
                if (!r_sub) v_value = r_ent.neg ? ('0 - r_ent.acc) : r_ent.acc;
            end
            ST_SHORT: v_column = v_first;
            default:  v_column = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_v <= 1'b0;
            r_sub   <= 1'b0;
        end else if (o_pop) begin
            r_ent_v <= 1'b1;
            r_sub   <= 1'b0;
        end else if (v_done) begin
            r_ent_v <= 1'b0;
            r_sub   <= 1'b0;
        end else if (v_load) begin
            r_sub   <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_ent <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (v_load) begin
            r_out_v <= 1'b1;
        end else if (o_out.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_load) begin
            r_out_value  <= $signed(v_value);
            r_out_column <= v_column;
            r_out_row    <= r_ent.row;
            r_out_status <= v_req.kind;
            r_out_last   <= v_req.last;
        end
    end

    assign o_out.valid       = r_out_v;
    assign o_out.value       = r_out_value;
    assign o_out.column      = r_out_column;
    assign o_out.row         = r_out_row;
    assign o_out.status      = r_out_status;
    assign o_out.last_in_row = r_out_last;

    a_second_exists: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ent_v && r_sub) |-> r_ent.has_b)
        else $error("second result of an entry that has only one");

endmodule

FILE: rtl/csv_column_integer_extractor.sv
// ----------------------------------------------------------------------------
// csv_column_integer_extractor
// Splits CSV text into lines and fields and returns selected columns as
// signed 64-bit integers with their column and row numbers.
// ----------------------------------------------------------------------------
// path: a result passes the queue, the entry register and the output register
// throughput: one byte per cycle while the queue has room; a byte causes at most
//   two results; the output register takes one result per cycle unless stalled
// the 4-entry request queue lets the parser run while the output is stalled
// reset: synchronous, active low; clears parser state, queue and output, and
//   returns the registers to their defaults (separators 44, others zero)
module csv_column_integer_extractor (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [csvcie_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [csvcie_pkg::CFG_DATA_W-1:0] i_cfg_data,
    csvcie_in_if.sink                         i_in,
    csvcie_out_if.source                      o_out
);
    import csvcie_pkg::*;

    // configuration registers
    t_cfg r_cfg;

    // parser to queue
    logic     w_push;
    t_q_entry w_push_entry;
    logic     w_not_full;

    // queue to result builder
    logic     w_pop;
    t_q_entry w_head_entry;
    logic     w_not_empty;

    // register writes (unchecked); host must write only while nothing is in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.field_sep    <= FIELD_SEP_RST;
            r_cfg.group_sep    <= GROUP_SEP_RST;
            r_cfg.col_mask     <= '0;
            r_cfg.rows_to_skip <= '0;
            r_cfg.row_limit    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FIELD_SEP: r_cfg.field_sep    <= i_cfg_data[BYTE_W-1:0];
                CFG_GROUP_SEP: r_cfg.group_sep    <= i_cfg_data[BYTE_W-1:0];
                CFG_COL_MASK:  r_cfg.col_mask     <= i_cfg_data[MASK_W-1:0];
                CFG_ROWS_SKIP: r_cfg.rows_to_skip <= i_cfg_data[ROW_W-1:0];
                CFG_ROW_LIMIT: r_cfg.row_limit    <= i_cfg_data[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    // front: takes a byte each cycle the queue has room, tracks lines and
    // fields, and pushes one entry for every byte that causes results
    csvcie_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_cfg        (r_cfg),
        .i_q_not_full (w_not_full),
        .o_push       (w_push),
        .o_entry      (w_push_entry)
    );

    // request queue decoupling parser and result builder
    csvcie_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_entry     (w_push_entry),
        .o_not_full  (w_not_full),
        .i_pop       (w_pop),
        .o_entry     (w_head_entry),
        .o_not_empty (w_not_empty)
    );

    // back: sign, first missing column search, output register
    csvcie_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_col_mask    (r_cfg.col_mask),
        .i_entry       (w_head_entry),
        .i_entry_valid (w_not_empty),
        .o_pop         (w_pop),
        .o_out         (o_out)
    );

endmodule

FILE: sim/csvcie_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvcie_tb_pkg
// Result tracking for the CSV column integer extractor bench: a bit-exact
// byte parser that queues the results each accepted byte should cause, and
// an in-order comparison of the results the block returns.
// ----------------------------------------------------------------------------
package csvcie_tb_pkg;
    import csvcie_pkg::*;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
        t_status          status;
        logic             last;
    } t_csv_result;

    class extract_scoreboard;
        // register copies
        logic [BYTE_W-1:0] field_sep;
        logic [BYTE_W-1:0] group_sep;
        logic [MASK_W-1:0] col_mask;
        logic [ROW_W-1:0]  lead_rows;
        logic [ROW_W-1:0]  last_row;

        // parser state
        int unsigned       col_cnt;
        int unsigned       sel_fields;
        logic [VAL_W-1:0]  acc;
        bit                neg;
        bit                at_start;
        bit                num_done;
        bit                line_open;
        bit                cr_seen;
        bit                halted;
        logic [ROW_W-1:0]  line_no;

        t_csv_result       expected_results[$];
        int unsigned       errors;
        int unsigned       checked;
        int unsigned       bytes_in;
        int unsigned       live_bytes;

        function new();
            field_sep  = FIELD_SEP_RST;
            group_sep  = GROUP_SEP_RST;
            col_mask   = '0;
            lead_rows  = '0;
            last_row   = '0;
            errors     = 0;
            checked    = 0;
            bytes_in   = 0;
            live_bytes = 0;
            restart_file();
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_FIELD_SEP: field_sep = d[BYTE_W-1:0];
                CFG_GROUP_SEP: group_sep = d[BYTE_W-1:0];
                CFG_COL_MASK:  col_mask  = d[MASK_W-1:0];
                CFG_ROWS_SKIP: lead_rows = d[ROW_W-1:0];
                CFG_ROW_LIMIT: last_row  = d[ROW_W-1:0];
                default: ;
            endcase
        endfunction

        function void clear_field();
            acc      = '0;
            neg      = 1'b0;
            at_start = 1'b1;
            num_done = 1'b0;
        endfunction

        function void clear_line();
            clear_field();
            col_cnt    = 0;
            sel_fields = 0;
            line_open  = 1'b0;
            cr_seen    = 1'b0;
        endfunction

        function void restart_file();
            clear_line();
            line_no = '0;
            halted  = 1'b0;
        endfunction

        function bit selected(int unsigned c);
            return (c < MAX_COLUMNS) ? col_mask[c] : 1'b0;
        endfunction

        function bit row_live();
            return line_no > lead_rows;
        endfunction

        function logic [VAL_W-1:0] field_value();
            return neg ? (VAL_W'(0) - acc) : acc;
        endfunction

        function void push_result(logic [VAL_W-1:0] v, int unsigned col,
                                  t_status st, bit last_flag);
            t_csv_result r;
            r.value  = v;
            r.column = COL_W'(col);
            r.row    = line_no;
            r.status = st;
            r.last   = last_flag;
            expected_results.insert(expected_results.size(), r);
        endfunction

        // one byte of field text: sign, digits, group bytes skipped
        function void field_char(logic [BYTE_W-1:0] b);
            if (num_done) return;
            if (at_start && b == CH_MINUS) begin
                neg      = 1'b1;
                at_start = 1'b0;
                return;
            end
            at_start = 1'b0;
            if (b != CH_CR && b == group_sep) return;
            if (b >= CH_ZERO && b <= CH_NINE) begin
                acc = acc * VAL_W'(10) + VAL_W'(b - CH_ZERO);
            end else begin
                num_done = 1'b1;
            end
        endfunction

        function void close_field();
            if (selected(col_cnt)) begin
                if (row_live()) push_result(field_value(), col_cnt, ST_VALUE, 1'b0);
                if (sel_fields < 127) sel_fields++;
            end
            if (col_cnt < MAX_COLUMNS) col_cnt++;
            clear_field();
        endfunction

        function void close_row();
            logic [MASK_W-1:0] rest;
            int unsigned       want;
            int unsigned       have;
            int unsigned       missing;
            bit                cur;
            if (row_live()) begin
                cur  = selected(col_cnt);
                want = $countones(col_mask);
                have = sel_fields + cur;
                if (have < want) begin
                    rest = (col_cnt >= 63) ? '0
                         : col_mask & ~((MASK_W'(1) << (col_cnt + 1)) - MASK_W'(1));
                    missing = 64;
                    for (int i = MASK_W - 1; i >= 0; i--) begin
                        if (rest[i]) missing = i;
                    end
                    push_result('0, missing, ST_SHORT, 1'b1);
                end else if (cur) begin
                    push_result(field_value(), col_cnt, ST_VALUE, 1'b1);
                end
            end
            clear_line();
        endfunction

        // expected results of one accepted byte, in order
        function void accept_byte(logic [BYTE_W-1:0] b, bit eof);
            bit go;
            bytes_in++;
            if (!halted) begin
                live_bytes++;
                if (b == CH_LF) begin
                    if (line_open) close_row();
                    else clear_line();
                end else if (b == CH_CR && !line_open && !cr_seen) begin
                    cr_seen = 1'b1;
                    field_char(b);
                end else begin
                    go = 1'b1;
                    if (!line_open) begin
                        line_open = 1'b1;
                        cr_seen   = 1'b0;
                        if (line_no != ROW_MAX) line_no++;
                        if (last_row != 0 && line_no > last_row) begin
                            push_result('0, 0, ST_LIMIT, 1'b0);
                            halted = 1'b1;
                            go     = 1'b0;
                        end
                    end
                    if (go) begin
                        if (b != CH_CR && b == field_sep) close_field();
                        else field_char(b);
                    end
                end
                if (eof && !halted && line_open) close_row();
            end
            if (eof) restart_file();
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_result(t_csv_result got);
            t_csv_result want;
            checked++;
            if (expected_results.size() == 0) begin
                report($sformatf("unexpected result value %0d col %0d row %0d status %0d last %0d",
                                 $signed(got.value), got.column, got.row, got.status,
                                 got.last));
                return;
            end
            want = expected_results.pop_front();
            if (got.value !== want.value || got.column !== want.column ||
                got.row !== want.row || got.status !== want.status ||
                got.last !== want.last) begin
                report($sformatf({"got value %0d col %0d row %0d status %0d last %0d, ",
                                  "want value %0d col %0d row %0d status %0d last %0d"},
                                 $signed(got.value), got.column, got.row, got.status,
                                 got.last, $signed(want.value), want.column, want.row,
                                 want.status, want.last));
            end
        endtask

        task flush_leftovers();
            t_csv_result want;
            while (expected_results.size() != 0) begin
                want = expected_results.pop_front();
                report($sformatf("missing result value %0d col %0d row %0d status %0d",
                                 $signed(want.value), want.column, want.row, want.status));
            end
        endtask

        function int unsigned pending();
            return expected_results.size();
        endfunction
    endclass

endpackage

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the CSV column integer extractor: a few hand-made lines on the
// separators, sign, empty lines, short rows and the row limit, then random
// CSV text under random register settings, with random idle bursts on both
// handshakes. Every returned result is checked in order against a parser
// model kept in step with the accepted bytes.
// ----------------------------------------------------------------------------
module tb_top;
    import csvcie_pkg::*;
    import csvcie_tb_pkg::*;

    localparam int RANDOM_BYTES = 1450;
    localparam int DRAIN_LIMIT  = 5000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    csvcie_in_if  byte_if();
    csvcie_out_if result_if();

    csv_column_integer_extractor u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (byte_if),
        .o_out      (result_if)
    );

    extract_scoreboard board;
    t_csv_result       got_result;

    // idle controls, changed per phase; quiet turns all idling off
    int unsigned gap_pct   = 0;
    int unsigned stall_pct = 0;
    bit          quiet     = 1'b0;
    int unsigned stall_left = 0;
    int unsigned settings_cnt = 0;

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // result side back-pressure: random bursts of stalled cycles
    always @(posedge i_clk) begin
        if (quiet) begin
            stall_left      <= 0;
            result_if.ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left      <= stall_left - 1;
            result_if.ready <= 1'b0;
        end else if ($urandom_range(99) < stall_pct) begin
            stall_left      <= $urandom_range(18, 0);
            result_if.ready <= 1'b0;
        end else begin
            result_if.ready <= 1'b1;
        end
    end

    // monitors: results are checked before the byte of the same edge is noted,
    // a byte's results always come later than its own edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (result_if.valid && result_if.ready) begin
                got_result.value  = result_if.value;
                got_result.column = result_if.column;
                got_result.row    = result_if.row;
                got_result.status = t_status'(result_if.status);
                got_result.last   = result_if.last_in_row;
                board.check_result(got_result);
            end
            if (byte_if.valid && byte_if.ready) begin
                board.accept_byte(byte_if.data_byte, byte_if.end_of_file);
            end
        end
    end

    // one byte request; valid stays high into the next call unless a gap follows
    task automatic send_byte(input logic [BYTE_W-1:0] b, input bit eof);
        byte_if.valid       <= 1'b1;
        byte_if.data_byte   <= b;
        byte_if.end_of_file <= eof;
        @(posedge i_clk);
        while (!byte_if.ready) @(posedge i_clk);
        if (!quiet && $urandom_range(99) < gap_pct) begin
            byte_if.valid <= 1'b0;
            repeat ($urandom_range(19, 1)) @(posedge i_clk);
        end
    endtask

    // literal text, end of file optionally marked on its last byte
    task automatic send_text(input string s, input bit eof_last);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], eof_last && (i == s.len() - 1));
        end
    endtask

    // register write while the parser is idle; model follows at once
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] d);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        board.write_reg(idx, d);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // stop sending and let every expected result come back, then let the
    // pipeline settle in case the last bytes caused nothing
    task automatic drain_results();
        byte_if.valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // new register setting, extremes and separator clashes included
    task automatic apply_random_settings();
        logic [BYTE_W-1:0] fs;
        logic [BYTE_W-1:0] gs;
        logic [MASK_W-1:0] mask;
        logic [ROW_W-1:0]  skip;
        logic [ROW_W-1:0]  lim;
        case ($urandom_range(9))
            0, 1, 2, 3: fs = 8'h2C;
            4:          fs = 8'h3B;
            5:          fs = 8'h09;
            6:          fs = 8'h7C;
            7:          fs = BYTE_W'($urandom_range(255));
            8:          fs = CH_LF;                // line end wins over the separator
            default: begin
                case ($urandom_range(3))
                    0:       fs = CH_CR;           // never splits fields
                    1:       fs = CH_MINUS;
                    2:       fs = CH_ZERO + BYTE_W'($urandom_range(9));
                    default: fs = $urandom_range(1) ? 8'hFF : 8'h00;
                endcase
            end
        endcase
        case ($urandom_range(9))
            0, 1, 2: gs = 8'h27;
            3:       gs = 8'h5F;
            4:       gs = fs;                      // separator wins over group byte
            5:       gs = 8'h2C;
            6:       gs = CH_MINUS;                // sign wins at field start
            7:       gs = CH_CR;
            8:       gs = CH_ZERO + BYTE_W'($urandom_range(9));
            default: gs = $urandom_range(1) ? 8'hFF : 8'h00;
        endcase
        case ($urandom_range(7))
            0:       mask = '0;
            1:       mask = '1;
            2:       mask = {$urandom, $urandom};
            3:       mask = MASK_W'(1) << $urandom_range(63);
            7:       mask = {1'b1, 55'd0, 8'($urandom_range(255))};
            default: mask = MASK_W'($urandom_range(255));
        endcase
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: skip = '0;
            6, 7:             skip = ROW_W'($urandom_range(4, 1));
            8:                skip = ROW_MAX;
            default:          skip = $urandom;
        endcase
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: lim = '0;
            6, 7:             lim = ROW_W'($urandom_range(12, 1));
            8:                lim = ROW_MAX;
            default:          lim = ROW_W'(1);
        endcase
        write_reg(CFG_FIELD_SEP, CFG_DATA_W'(fs));
        write_reg(CFG_GROUP_SEP, CFG_DATA_W'(gs));
        write_reg(CFG_COL_MASK,  CFG_DATA_W'(mask));
        write_reg(CFG_ROWS_SKIP, CFG_DATA_W'(skip));
        write_reg(CFG_ROW_LIMIT, CFG_DATA_W'(lim));
        settings_cnt++;
    endtask

    // one random line: mostly well-formed numeric fields, some noise,
    // some empty or CR-only lines, now and then a very wide line
    task automatic send_random_line(input bit close_file);
        logic [BYTE_W-1:0] text[$];
        logic [BYTE_W-1:0] b;
        int                ending;
        int                ncols;
        int                kind;
        int                ndig;
        ending = $urandom_range(19);
        if (ending == 0) begin
            text.insert(text.size(), CH_LF);
        end else if (ending == 1) begin
            text.insert(text.size(), CH_CR);
            text.insert(text.size(), CH_LF);
        end else if (ending == 2) begin
            // second CR opens a real line
            text.insert(text.size(), CH_CR);
            text.insert(text.size(), CH_CR);
            text.insert(text.size(), CH_LF);
        end else begin
            ncols = ($urandom_range(24) == 0) ? $urandom_range(70, 60) : $urandom_range(8, 1);
            for (int c = 0; c < ncols; c++) begin
                if (c != 0) text.insert(text.size(), board.field_sep);
                kind = $urandom_range(19);
                if (kind < 13) begin
                    if ($urandom_range(3) == 0) text.insert(text.size(), CH_MINUS);
                    if ($urandom_range(15) == 0) text.insert(text.size(), board.group_sep);
                    // long digit runs wrap past 64 bits
                    ndig = ($urandom_range(19) == 0) ? $urandom_range(25, 15)
                                                     : $urandom_range(6, 1);
                    for (int d = 0; d < ndig; d++) begin
                        b = CH_ZERO + BYTE_W'($urandom_range(9));
                        text.insert(text.size(), b);
                        if (d + 1 < ndig && $urandom_range(4) == 0) begin
                            text.insert(text.size(), board.group_sep);
                        end
                    end
                end else if (kind < 15) begin
                    // empty field
                end else if (kind < 19) begin
                    // junk that keeps the line intact
                    repeat ($urandom_range(3, 1)) begin
                        b = BYTE_W'($urandom_range(255));
                        if (b == CH_LF || b == board.field_sep) b = 8'h78;
                        text.insert(text.size(), b);
                    end
                end else begin
                    b = BYTE_W'($urandom_range(255));
                    text.insert(text.size(), b);
                end
            end
            case ($urandom_range(3))
                0, 1: text.insert(text.size(), CH_LF);
                2: begin
                    text.insert(text.size(), CH_CR);
                    text.insert(text.size(), CH_LF);
                end
                default: begin
                    // open line left for the end-of-file mark to close
                    if (!close_file) text.insert(text.size(), CH_LF);
                end
            endcase
        end
        for (int i = 0; i < text.size(); i++) begin
            send_byte(text[i], (close_file && i == text.size() - 1) ||
                               ($urandom_range(299) == 0));
        end
    endtask

    initial begin
        int unsigned base_bytes;
        int          nlines;
        bit          close_file;
        int          waited;

        board = new();
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_idx           <= CFG_FIELD_SEP;
        i_cfg_data          <= '0;
        byte_if.valid       <= 1'b0;
        byte_if.data_byte   <= '0;
        byte_if.end_of_file <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        gap_pct   = 25;
        stall_pct = 25;

        // register defaults: no column selected, so nothing comes back
        send_text("1,2\n", 1'b0);
        drain_results();

        // only the mask written; separators keep their reset comma
        write_reg(CFG_COL_MASK, CFG_DATA_W'(3));
        send_text("-12,7\015\n", 1'b0);    // negative value, CR ends a number
        send_text("\015\n", 1'b0);         // CR-only line is ignored
        send_text("\n", 1'b0);             // empty line is ignored
        send_text("5\n", 1'b0);            // short of column 1
        send_byte(8'h00, 1'b0);            // lowest byte ends the number at once
        send_text(",", 1'b0);
        send_byte(8'hFF, 1'b1);            // highest byte, end of file closes the line
        drain_results();

        // all registers: skip the header, limit after row 2
        write_reg(CFG_FIELD_SEP, CFG_DATA_W'(8'h3B));
        write_reg(CFG_GROUP_SEP, CFG_DATA_W'(8'h2C));
        write_reg(CFG_COL_MASK,  CFG_DATA_W'(1));
        write_reg(CFG_ROWS_SKIP, CFG_DATA_W'(1));
        write_reg(CFG_ROW_LIMIT, CFG_DATA_W'(2));
        settings_cnt += 2;
        send_text("h\n", 1'b0);            // skipped header
        send_text("-,1,2;9\n", 1'b0);      // sign then group bytes
        send_text("3", 1'b0);              // row over the limit
        send_text("4", 1'b1);              // ignored until end of file
        drain_results();

        // random phases: new setting, a batch of lines, drain
        base_bytes = board.bytes_in;
        while ((board.bytes_in - base_bytes) < RANDOM_BYTES) begin
            quiet = (board.bytes_in - base_bytes) > (RANDOM_BYTES * 4) / 5;
            case ($urandom_range(3))
                0:       gap_pct = 0;
                1:       gap_pct = 10;
                2:       gap_pct = 35;
                default: gap_pct = 70;
            endcase
            case ($urandom_range(3))
                0:       stall_pct = 0;
                1:       stall_pct = 10;
                2:       stall_pct = 35;
                default: stall_pct = 70;
            endcase
            apply_random_settings();
            // a row limit halts the parser until end of file, so close it then
            close_file = (board.last_row != 0) || ($urandom_range(1) == 1);
            nlines = $urandom_range(12, 3);
            for (int l = 0; l < nlines; l++) begin
                send_random_line(close_file && l == nlines - 1);
            end
            drain_results();
        end

        // final drain with a bound, then settle
        quiet = 1'b1;
        byte_if.valid <= 1'b0;
        waited = 0;
        @(posedge i_clk);
        while (board.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (10) @(posedge i_clk);
        board.flush_leftovers();

        $display("run covered %0d text bytes (%0d parsed) under %0d register settings",
                 board.bytes_in, board.live_bytes, settings_cnt);
        $display("%0d results compared, %0d mismatches", board.checked, board.errors);
        if (board.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #2000000;
        $display("timeout: results still pending %0d", board.pending());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: sim.f
rtl/csvcie_pkg.sv
rtl/csvcie_in_if.sv
rtl/csvcie_out_if.sv
rtl/csvcie_front.sv
rtl/csvcie_queue.sv
rtl/csvcie_back.sv
rtl/csv_column_integer_extractor.sv
sim/csvcie_tb_pkg.sv
sim/tb_top.sv
